// ----- design/rbcef_pkg.sv -----
// ---------------------------------------------------------------------------
// rbcef_pkg
// Shared constants and types of the ring buffer comb / echo filter.
// ---------------------------------------------------------------------------
`default_nettype none

package rbcef_pkg;

    localparam int DEF_MAX_DELAY    = 65536;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 15;
    localparam int LEN_W     = 17;
    localparam int MODE_W    = 2;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_DELAY = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_FF  = 2'd0,
        MODE_FB  = 2'd1,
        MODE_WET = 2'd2
    } mode_t;

    localparam logic [MODE_W-1:0] MODE_RST  = MODE_FF;
    localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd29491;
    localparam logic [LEN_W-1:0]  DELAY_RST = 17'd1;

endpackage

`default_nettype wire

// ----- design/rbcef_regs.sv -----
// ---------------------------------------------------------------------------
// rbcef_regs
// APB register file: filter mode, gain and delay length.
// ---------------------------------------------------------------------------
`default_nettype none

module rbcef_regs
    import rbcef_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready,
    output logic      [MODE_W-1:0]   filter_mode,
    output logic      [GAIN_W-1:0]   gain,
    output logic      [LEN_W-1:0]    delay_length
);

    logic [MODE_W-1:0] mode_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [LEN_W-1:0]  delay_reg;
    logic              wr_req;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_req  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RST;
            gain_reg  <= GAIN_RST;
            delay_reg <= DELAY_RST;
        end
        else if (wr_req)
        begin
            unique case (reg_idx)
                REG_MODE:  mode_reg  <= pwdata[MODE_W-1:0];
                REG_GAIN:  gain_reg  <= pwdata[GAIN_W-1:0];
                REG_DELAY: delay_reg <= pwdata[LEN_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:  prdata = {{(APB_DW-MODE_W){1'b0}}, mode_reg};
            REG_GAIN:  prdata = {{(APB_DW-GAIN_W){gain_reg[GAIN_W-1]}}, gain_reg};
            REG_DELAY: prdata = {{(APB_DW-LEN_W){1'b0}}, delay_reg};
            default:   prdata = '0;
        endcase
    end

    assign filter_mode  = mode_reg;
    assign gain         = gain_reg;
    assign delay_length = delay_reg;

endmodule

`default_nettype wire

// ----- design/rbcef_ring.sv -----
// ---------------------------------------------------------------------------
// rbcef_ring
// Delay ring: ring pointer, sample memory, fill count and read forwarding.
// ---------------------------------------------------------------------------
`default_nettype none

module rbcef_ring
    import rbcef_pkg::*;
#(
    parameter int MAX_DELAY    = DEF_MAX_DELAY,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [LEN_W-1:0]        delay_length,
    input  wire logic                    accept,
    input  wire logic                    wr_en,
    input  wire logic                    fwd_valid,
    input  wire logic [AW-1:0]           wr_addr,
    input  wire logic [SAMPLE_WIDTH-1:0] wr_data,
    output logic      [AW-1:0]           s1_addr,
    output logic      [SAMPLE_WIDTH-1:0] delayed
);

    localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_DELAY);

    logic [SAMPLE_WIDTH-1:0] mem [MAX_DELAY];

    logic [AW-1:0]           ptr_reg;
    logic [AW-1:0]           ptr_next;
    logic [AW:0]             fill_reg;
    logic [AW:0]             fill_next;
    logic [AW-1:0]           s1_addr_reg;
    logic [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic                    last_valid_reg;
    logic [AW-1:0]           last_addr_reg;
    logic [SAMPLE_WIDTH-1:0] last_data_reg;

    logic [CW-1:0]           dl_ext;
    logic [CW-1:0]           len_c;
    logic [AW-1:0]           ptr_cur;
    logic [CW-1:0]           ptr_inc;

    // effective ring length and wrap
    always_comb
    begin
        dl_ext = CW'(delay_length);
        if (dl_ext == '0)
            len_c = CW'(1);
        else if (dl_ext > MAX_LEN)
            len_c = MAX_LEN;
        else
            len_c = dl_ext;

        ptr_cur  = (CW'(ptr_reg) >= len_c) ? '0 : ptr_reg;
        ptr_inc  = CW'(ptr_cur) + CW'(1);
        ptr_next = (ptr_inc >= len_c) ? '0 : ptr_inc[AW-1:0];
    end

    // entries are written in pointer order, so the written set is a prefix
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && ({1'b0, wr_addr} >= fill_reg))
            fill_next = {1'b0, wr_addr} + (AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            fill_reg       <= '0;
            last_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                ptr_reg <= ptr_next;
            fill_reg <= fill_next;
            if (wr_en)
                last_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            last_addr_reg <= wr_addr;
            last_data_reg <= wr_data;
        end
        if (accept)
            s1_addr_reg <= ptr_cur;
    end

    // sample memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (accept)
            rd_data_reg <= mem[ptr_cur];
    end

    // newest pending write wins, unwritten entries read as zero
    always_comb
    begin
        if (fwd_valid && (wr_addr == s1_addr_reg))
            delayed = wr_data;
        else if (last_valid_reg && (last_addr_reg == s1_addr_reg))
            delayed = last_data_reg;
        else if ({1'b0, s1_addr_reg} < fill_reg)
            delayed = rd_data_reg;
        else
            delayed = '0;
    end

    assign s1_addr = s1_addr_reg;

endmodule

`default_nettype wire

// ----- design/rbcef_arith.sv -----
// ---------------------------------------------------------------------------
// rbcef_arith
// Gain multiply stage, saturating sum, mode select and output registers.
// ---------------------------------------------------------------------------
`default_nettype none

module rbcef_arith
    import rbcef_pkg::*;
#(
    parameter int MAX_DELAY    = DEF_MAX_DELAY,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1
)
(
    input  wire logic                    clk,
    input  wire logic                    accept,
    input  wire logic                    advance,
    input  wire logic [SAMPLE_WIDTH-1:0] in_sample,
    input  wire logic [MODE_W-1:0]       filter_mode,
    input  wire logic [GAIN_W-1:0]       gain,
    input  wire logic [SAMPLE_WIDTH-1:0] delayed,
    input  wire logic [AW-1:0]           s1_addr,
    output logic      [AW-1:0]           wr_addr,
    output logic      [SAMPLE_WIDTH-1:0] wr_data,
    output logic      [SAMPLE_WIDTH-1:0] out_sample,
    output logic                         clipped
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int PW = W + GAIN_W;
    localparam logic [W-1:0] SMP_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMP_MIN = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]         x_s1_reg;
    logic [W-1:0]         x_s2_reg;
    logic [W-1:0]         d_s2_reg;
    logic [W:0]           prod_s2_reg;
    logic [AW-1:0]        addr_s2_reg;
    logic [W-1:0]         out_reg;
    logic                 clip_reg;

    logic signed [PW-1:0] prod_full;
    logic signed [PW-1:0] prod_shr;
    logic [W+1:0]         sum;
    logic                 ovf;
    logic [W-1:0]         sat_val;
    logic [W-1:0]         y;
    logic [W-1:0]         st;

    assign prod_full = $signed(gain) * $signed(delayed);
    assign prod_shr  = prod_full >>> GAIN_FRAC;

    always_ff @(posedge clk)
    begin
        if (accept)
            x_s1_reg <= in_sample;
        if (advance)
        begin
            x_s2_reg    <= x_s1_reg;
            d_s2_reg    <= delayed;
            prod_s2_reg <= prod_shr[W:0];
            addr_s2_reg <= s1_addr;
            out_reg     <= y;
            clip_reg    <= ovf;
        end
    end

    always_comb
    begin
        sum = {{2{x_s2_reg[W-1]}}, x_s2_reg} + {prod_s2_reg[W], prod_s2_reg};
        ovf = !((sum[W+1:W-1] == 3'b000) || (sum[W+1:W-1] == 3'b111));
        if (!ovf)
            sat_val = sum[W-1:0];
        else if (sum[W+1])
            sat_val = SMP_MIN;
        else
            sat_val = SMP_MAX;

        case (filter_mode)
            MODE_FB:
            begin
                y  = sat_val;
                st = sat_val;
            end
            MODE_WET:
            begin
                y  = d_s2_reg;
                st = sat_val;
            end
            default:
            begin
                y  = sat_val;
                st = x_s2_reg;
            end
        endcase
    end

    assign wr_addr    = addr_s2_reg;
    assign wr_data    = st;
    assign out_sample = out_reg;
    assign clipped    = clip_reg;

endmodule

`default_nettype wire

// ----- design/ring_buffer_comb_echo_filter.sv -----
// ---------------------------------------------------------------------------
// ring_buffer_comb_echo_filter
// Comb / echo filter over a circular delay memory with Q1.15 gain.
// ---------------------------------------------------------------------------
//  channel   | direction | signals
//  ----------+-----------+---------------------------------------------------
//  s_*       | in        | tvalid, tready, tdata = in_sample
//  m_*       | out       | tvalid, tready, tdata = out_sample, tuser = clipped
//  apb       | in / out  | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
//  one request per cycle sustained while m_tready holds; m_tvalid rises once the
//  request has passed memory read, gain multiply and sum into the output register
//  the delay memory takes one read and one write per cycle; recent writes
//  are forwarded so a delay of one or two samples runs at full rate
//  after reset the memory reads as zero via a fill count, no clearing pass
//  a stalled m side freezes the whole pipeline; s_tready drops only then
// ---------------------------------------------------------------------------
`default_nettype none

module ring_buffer_comb_echo_filter
    import rbcef_pkg::*;
#(
    parameter int MAX_DELAY    = DEF_MAX_DELAY,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    localparam int TW = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [TW-1:0]     s_tdata,   // in_sample
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [TW-1:0]     m_tdata,   // out_sample
    output logic                   m_tuser,   // clipped
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [MODE_W-1:0]       filter_mode;
    logic [GAIN_W-1:0]       gain;
    logic [LEN_W-1:0]        delay_length;

    logic                    advance;
    logic                    accept;
    logic                    wr_en;
    logic                    s1_valid_reg;
    logic                    s2_valid_reg;
    logic                    out_valid_reg;

    logic [AW-1:0]           s1_addr;
    logic [SAMPLE_WIDTH-1:0] delayed;
    logic [AW-1:0]           wr_addr;
    logic [SAMPLE_WIDTH-1:0] wr_data;
    logic [SAMPLE_WIDTH-1:0] out_sample;
    logic                    clipped;

    assign advance  = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && advance;
    assign wr_en    = s2_valid_reg && advance;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    rbcef_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .filter_mode  (filter_mode),
        .gain         (gain),
        .delay_length (delay_length)
    );

    rbcef_ring #(
        .MAX_DELAY    (MAX_DELAY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ring
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .delay_length (delay_length),
        .accept       (accept),
        .wr_en        (wr_en),
        .fwd_valid    (s2_valid_reg),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .s1_addr      (s1_addr),
        .delayed      (delayed)
    );

    rbcef_arith #(
        .MAX_DELAY    (MAX_DELAY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_arith
    (
        .clk          (clk),
        .accept       (accept),
        .advance      (advance),
        .in_sample    (s_tdata[SAMPLE_WIDTH-1:0]),
        .filter_mode  (filter_mode),
        .gain         (gain),
        .delayed      (delayed),
        .s1_addr      (s1_addr),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .out_sample   (out_sample),
        .clipped      (clipped)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TW'(out_sample);
    assign m_tuser  = clipped;

    // write-back stays inside the ring
    a_wr_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((AW+1)'(wr_addr) < (AW+1)'(MAX_DELAY)))
        else $error("write address beyond ring");

    // an item in the write-back stage reaches the output on advance
    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> m_tvalid)
        else $error("write-back without output");

    // an accepted request enters the multiply stage
    a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request lost");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stream-level check of the comb / echo filter. Samples go in over the s side
// and the m side results are compared against an in-bench ring and gain model
// or fixed table values. Mode, gain and delay are set over the register port,
// only while the filter is drained. A short table of edge cases runs first,
// then random phases with varied settings and idling on both sides.
// ---------------------------------------------------------------------------
module tb_top;
    import rbcef_pkg::*;

    localparam int RING_DEPTH = 65536;
    localparam int PHASES = 9;
    localparam int PHASE_REQUESTS = 55;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_e;

    typedef struct packed {
        logic [15:0] smp;
        logic        clip;
    } echo_res_t;

    typedef struct packed {
        row_kind_e   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        bit          fixed;
        logic [15:0] want_smp;
        logic        want_clip;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;           // in_sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;                // out_sample
    logic        m_tuser;                // clipped
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic        pready;

    // model state and settings
    logic signed [15:0] ring_mem [0:RING_DEPTH-1];
    int                 ring_ptr = 0;
    logic [MODE_W-1:0]  cfg_mode = MODE_RST;
    logic signed [15:0] cfg_gain = GAIN_RST;
    logic [LEN_W-1:0]   cfg_delay = DELAY_RST;

    echo_res_t echo_expect_q [$];
    int        mismatch_count = 0;
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;

    stim_row_t dir_rows [$] = '{
        '{ROW_SAMPLE, REG_MODE,  32'h7fff,  1'b1, 16'h7fff, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h7fff,  1'b1, 16'h7fff, 1'b1},
        '{ROW_SAMPLE, REG_MODE,  32'h8000,  1'b0, 16'h0000, 1'b0},
        '{ROW_WRITE,  REG_GAIN,  32'h8000,  1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h0000,  1'b1, 16'h7fff, 1'b1},
        '{ROW_WRITE,  REG_MODE,  32'(MODE_FB), 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h8000,  1'b1, 16'h8000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h8000,  1'b0, 16'h0000, 1'b0},
        '{ROW_WRITE,  REG_MODE,  32'(MODE_WET), 1'b0, 16'h0000, 1'b0},
        '{ROW_WRITE,  REG_GAIN,  32'h7fff,  1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h7fff,  1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h7fff,  1'b1, 16'h7fff, 1'b1},
        '{ROW_WRITE,  REG_MODE,  32'(MODE_UNUSED), 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h0064,  1'b0, 16'h0000, 1'b0},
        '{ROW_WRITE,  REG_DELAY, 32'h0,     1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'hffff,  1'b0, 16'h0000, 1'b0},
        '{ROW_WRITE,  REG_DELAY, 32'h3,     1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h1234,  1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'hedcb,  1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h5555,  1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'haaaa,  1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h0001,  1'b0, 16'h0000, 1'b0},
        '{ROW_WRITE,  REG_DELAY, 32'h2,     1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h7fff,  1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h8000,  1'b0, 16'h0000, 1'b0},
        '{ROW_WRITE,  REG_DELAY, 32'h10001, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h4000,  1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'hc000,  1'b0, 16'h0000, 1'b0},
        '{ROW_WRITE,  REG_DELAY, 32'h1ffff, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h0100,  1'b0, 16'h0000, 1'b0},
        '{ROW_WRITE,  REG_GAIN,  32'h0,     1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_MODE,  32'h8001,  1'b0, 16'h0000, 1'b0}
    };

    ring_buffer_comb_echo_filter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic echo_res_t echo_predict(input logic signed [15:0] x);
        int        eff_len;
        longint    d;
        longint    sum_v;
        longint    sat_v;
        longint    out_v;
        longint    st_v;
        echo_res_t r;
        eff_len = int'(cfg_delay);
        if (eff_len == 0)
            eff_len = 1;
        if (eff_len > RING_DEPTH)
            eff_len = RING_DEPTH;
        if (ring_ptr >= eff_len)
            ring_ptr = 0;
        d = ring_mem[ring_ptr];
        // q1.15 product, floor shift
        sum_v = longint'(x) + ((longint'(cfg_gain) * d) >>> GAIN_FRAC);
        sat_v = (sum_v > 32767) ? 32767 : ((sum_v < -32768) ? -32768 : sum_v);
        if (cfg_mode == MODE_FB)
        begin
            out_v = sat_v;
            st_v = sat_v;
        end
        else if (cfg_mode == MODE_WET)
        begin
            out_v = d;
            st_v = sat_v;
        end
        else
        begin
            out_v = sat_v;
            st_v = x;
        end
        ring_mem[ring_ptr] = st_v[15:0];
        ring_ptr++;
        if (ring_ptr >= eff_len)
            ring_ptr = 0;
        r.smp = out_v[15:0];
        r.clip = (sat_v != sum_v);
        return r;
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_MODE:  cfg_mode = val[MODE_W-1:0];
            REG_GAIN:  cfg_gain = val[GAIN_W-1:0];
            REG_DELAY: cfg_delay = val[LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_sample(input logic [15:0] v, input bit fixed, input echo_res_t want);
        echo_res_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do @(posedge clk); while (!s_tready);
        r = echo_predict(v);
        echo_expect_q.push_back(fixed ? want : r);
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (echo_expect_q.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        echo_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (echo_expect_q.size() == 0)
            begin
                $display("%0t unexpected result out=%0d clip=%0d", $time,
                         $signed(m_tdata), m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = echo_expect_q.pop_front();
                if (m_tdata !== want.smp || m_tuser !== want.clip)
                begin
                    $display("%0t mismatch: expected out=%0d clip=%0d, actual out=%0d clip=%0d",
                             $time, $signed(want.smp), want.clip, $signed(m_tdata), m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        logic [31:0] gain_v;
        logic [31:0] delay_v;
        logic [15:0] smp_v;
        foreach (ring_mem[i])
            ring_mem[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
            begin
                drain_pipe();
                reg_write(dir_rows[i].reg_idx, dir_rows[i].value);
            end
            else
                send_sample(dir_rows[i].value[15:0], dir_rows[i].fixed,
                            {dir_rows[i].want_smp, dir_rows[i].want_clip});
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_pipe();
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 21; sink_stall_pct = 21; end
            endcase
            case ($urandom_range(4))
                0: gain_v = 32'h7fff;
                1: gain_v = 32'h8000;
                2: gain_v = 32'hffff;
                default: gain_v = {16'h0, 16'($urandom)};
            endcase
            case ($urandom_range(9))
                0: delay_v = 32'h0;
                1: delay_v = RING_DEPTH;
                // overlong
                2: delay_v = 32'h10001 + $urandom_range(65534);
                default: delay_v = $urandom_range(24, 1);
            endcase
            reg_write(REG_MODE, {30'h0, 2'($urandom_range(3))});
            reg_write(REG_GAIN, gain_v);
            reg_write(REG_DELAY, delay_v);
            for (int k = 0; k < PHASE_REQUESTS; k++)
            begin
                case ($urandom_range(7))
                    0: smp_v = 16'h7fff;
                    1: smp_v = 16'h8000;
                    default: smp_v = 16'($urandom);
                endcase
                send_sample(smp_v, 1'b0, '0);
            end
        end

        drain_pipe();
        if (mismatch_count == 0 && echo_expect_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
